>>> rtl/grid_fit_factor_macros.svh
// ----------------------------------------------------------------------------
// grid_fit_factor_macros
// assertion macros shared by the grid fit modules
// ----------------------------------------------------------------------------
`ifndef GRID_FIT_FACTOR_MACROS_SVH
`define GRID_FIT_FACTOR_MACROS_SVH

`ifndef SYNTHESIS

// property checked while reset is released
`define GFF_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("grid_fit_factor assertion failed");

// property checked on every edge, reset included
`define GFF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("grid_fit_factor assertion failed");

`else

`define GFF_ASSERT_RST(lbl, clk, rst_n, prop)
`define GFF_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> rtl/gff_pkg.sv
// ----------------------------------------------------------------------------
// gff_pkg
// types and constants shared by the grid fit controller and datapath
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gff_pkg;

    localparam int GFF_COUNT_BITS = 16;
    localparam int GFF_FIELD_W    = 16;
    localparam logic [31:0] GFF_SMALL_LIMIT = 32'd20;

    // where the result word takes its columns and rows from
    typedef enum logic [1:0] {
        RES_SAME,
        RES_DIV,
        RES_SMALL,
        RES_CEIL
    } t_res_sel;

    typedef struct packed {
        logic     load;
        logic     sqrt_start;
        logic     sqrt_step;
        logic     div_start;
        logic     div_scan;
        logic     save_root;
        logic     scan_init;
        logic     scan_next;
        logic     res_load;
        t_res_sel res_sel;
    } t_cmd;

    typedef struct packed {
        logic prod_match;
        logic sqrt_last;
        logic div_done;
        logic rem_zero;
        logic scan_over;
        logic below_limit;
    } t_status;

endpackage

>>> rtl/grid_fit_factor.sv
// ----------------------------------------------------------------------------
// grid_fit_factor
// fits a near-square grid of columns by rows to an element count
// ----------------------------------------------------------------------------
// One word in gives one word out. A count that already equals columns times
// rows comes back unchanged. Otherwise the block takes an integer square
// root of the count (CW = COUNT_BITS capped at 16) and then runs divisions
// on a shared restoring divider: one by the root, then one per candidate
// row count from half to twice the root until one divides exactly. If none
// does, the result is the count by one row for counts below 20, else the
// ceiling of count over root by the root. The next word is taken once the
// block is back in idle; a result waiting in the output register does not
// hold that up.
`timescale 1ns / 1ps

module grid_fit_factor import gff_pkg::*; #(
    parameter int COUNT_BITS = GFF_COUNT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // element_count [15:0], current_cols [31:16], current_rows [47:32]
    input  logic [47:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // fitted_cols [15:0], fitted_rows [31:16]
    output logic [31:0] o_m_tdata,
    // changed [0]
    output logic [0:0]  o_m_tuser
);

    t_cmd    w_cmd;
    t_status w_status;
    logic [GFF_FIELD_W-1:0] w_cols;
    logic [GFF_FIELD_W-1:0] w_rows;
    logic                   w_chg;

    gff_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    gff_dpath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_element_count (i_s_tdata[15:0]),
        .i_current_cols  (i_s_tdata[31:16]),
        .i_current_rows  (i_s_tdata[47:32]),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_fitted_cols   (w_cols),
        .o_fitted_rows   (w_rows),
        .o_changed       (w_chg)
    );

    assign o_m_tdata = {w_rows, w_cols};
    assign o_m_tuser = w_chg;

endmodule

>>> rtl/gff_div.sv
// ----------------------------------------------------------------------------
// gff_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "grid_fit_factor_macros.svh"

module gff_div import gff_pkg::*; #(
    parameter int W = GFF_COUNT_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quo,
    output logic [W-1:0] o_rem,
    output logic [W-1:0] o_dvs
);

    localparam int CNT_W = $clog2(W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_dvs;

    logic [W:0]       w_shift;
    logic             w_fit;

    assign w_shift = {r_rem, r_quo[W-1]};
    assign w_fit   = w_shift >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[W-2:0], w_fit};
            r_rem <= w_fit ? W'(w_shift - {1'b0, r_dvs}) : w_shift[W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
    assign o_dvs  = r_dvs;

    `GFF_ASSERT_RST(a_div_no_restart, i_clk, i_rst_n, i_start |-> !r_busy)
    `GFF_ASSERT_RST(a_div_done_after_busy, i_clk, i_rst_n, r_done |-> $past(r_busy))
    `GFF_ASSERT_RST(a_div_rem_below, i_clk, i_rst_n, r_done |-> (r_rem < r_dvs))

endmodule

>>> rtl/gff_dpath.sv
// ----------------------------------------------------------------------------
// gff_dpath
// operand registers, product, bit-pair square root, divisor scan and result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gff_dpath import gff_pkg::*; #(
    parameter int COUNT_BITS = GFF_COUNT_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [GFF_FIELD_W-1:0] i_element_count,
    input  logic [GFF_FIELD_W-1:0] i_current_cols,
    input  logic [GFF_FIELD_W-1:0] i_current_rows,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    output logic [GFF_FIELD_W-1:0] o_fitted_cols,
    output logic [GFF_FIELD_W-1:0] o_fitted_rows,
    output logic                   o_changed
);

    localparam int CW    = (COUNT_BITS < GFF_FIELD_W) ? COUNT_BITS : GFF_FIELD_W;
    localparam int HALF  = (CW + 1) / 2;
    localparam int SQW   = 2 * HALF;
    localparam int SCW   = $clog2(HALF + 1);
    localparam int RW    = HALF + 2;

    logic [CW-1:0]      r_n;
    logic [CW-1:0]      r_cx;
    logic [CW-1:0]      r_cy;
    logic [2*CW-1:0]    r_prod;

    logic [SQW-1:0]     r_sv;
    logic [SQW-1:0]     r_sr;
    logic [SQW-1:0]     r_sbit;
    logic [SCW-1:0]     r_sq_cnt;

    logic [CW-1:0]      r_ceil;
    logic [RW-1:0]      r_scan;
    logic [RW-1:0]      r_hi;

    logic [GFF_FIELD_W-1:0] r_cols;
    logic [GFF_FIELD_W-1:0] r_rows;
    logic                   r_chg;

    logic [SQW:0]       w_sq_try;
    logic               w_sq_fit;
    logic [CW-1:0]      w_root;
    logic [RW-1:0]      w_root_rw;
    logic [RW-1:0]      w_lo;
    logic [CW-1:0]      w_divisor;
    logic               w_div_done;
    logic [CW-1:0]      w_quo;
    logic [CW-1:0]      w_rem;
    logic [CW-1:0]      w_dvs;

    assign w_sq_try  = (SQW+1)'(r_sr) + (SQW+1)'(r_sbit);
    assign w_sq_fit  = {1'b0, r_sv} >= w_sq_try;

    // root is at least one
    assign w_root    = (r_sr == '0) ? CW'(1) : CW'(r_sr);
    assign w_root_rw = RW'(w_root);
    assign w_lo      = ((w_root_rw >> 1) == '0) ? RW'(1) : (w_root_rw >> 1);
    assign w_divisor = i_cmd.div_scan ? CW'(r_scan) : w_root;

    gff_div #(
        .W (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_n),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quo      (w_quo),
        .o_rem      (w_rem),
        .o_dvs      (w_dvs)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n  <= i_element_count[CW-1:0];
            r_cx <= i_current_cols[CW-1:0];
            r_cy <= i_current_rows[CW-1:0];
        end
        r_prod <= (2*CW)'(r_cx) * (2*CW)'(r_cy);

        if (i_cmd.sqrt_start) begin
            r_sv     <= SQW'(r_n);
            r_sr     <= '0;
            r_sbit   <= SQW'(1) << (SQW - 2);
            r_sq_cnt <= SCW'(HALF);
        end else if (i_cmd.sqrt_step) begin
            if (w_sq_fit) begin
                r_sv <= r_sv - SQW'(w_sq_try);
                r_sr <= (r_sr >> 1) + r_sbit;
            end else begin
                r_sr <= r_sr >> 1;
            end
            r_sbit   <= r_sbit >> 2;
            r_sq_cnt <= r_sq_cnt - SCW'(1);
        end

        // ceiling of count over root, kept for the fallback
        if (i_cmd.save_root) begin
            r_ceil <= w_quo + CW'(w_rem != '0);
        end

        if (i_cmd.scan_init) begin
            r_scan <= w_lo;
            r_hi   <= w_root_rw << 1;
        end else if (i_cmd.scan_next) begin
            r_scan <= r_scan + RW'(1);
        end

        if (i_cmd.res_load) begin
            unique case (i_cmd.res_sel)
                RES_SAME: begin
                    r_cols <= GFF_FIELD_W'(r_cx);
                    r_rows <= GFF_FIELD_W'(r_cy);
                    r_chg  <= 1'b0;
                end
                RES_DIV: begin
                    r_cols <= GFF_FIELD_W'(w_quo);
                    r_rows <= GFF_FIELD_W'(w_dvs);
                    r_chg  <= 1'b1;
                end
                RES_SMALL: begin
                    r_cols <= GFF_FIELD_W'(r_n);
                    r_rows <= GFF_FIELD_W'(1);
                    r_chg  <= 1'b1;
                end
                RES_CEIL: begin
                    r_cols <= GFF_FIELD_W'(r_ceil);
                    r_rows <= GFF_FIELD_W'(w_root);
                    r_chg  <= 1'b1;
                end
                default: begin
                    r_cols <= GFF_FIELD_W'(r_ceil);
                    r_rows <= GFF_FIELD_W'(w_root);
                    r_chg  <= 1'b1;
                end
            endcase
        end
    end

    assign o_status.prod_match  = (r_prod == (2*CW)'(r_n));
    assign o_status.sqrt_last   = (r_sq_cnt == SCW'(1));
    assign o_status.div_done    = w_div_done;
    assign o_status.rem_zero    = (w_rem == '0);
    assign o_status.scan_over   = (r_scan > r_hi);
    assign o_status.below_limit = (32'(r_n) < GFF_SMALL_LIMIT);

    assign o_fitted_cols = r_cols;
    assign o_fitted_rows = r_rows;
    assign o_changed     = r_chg;

endmodule

>>> rtl/gff_ctrl.sv
// ----------------------------------------------------------------------------
// gff_ctrl
// sequencer for compare, square root, root check and divisor scan
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "grid_fit_factor_macros.svh"

module gff_ctrl import gff_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_CMP,
        S_SQRT,
        S_ROOT_DIV,
        S_DIV_ROOT,
        S_SCAN_CHK,
        S_DIV_SCAN,
        S_FINISH
    } t_state;

    t_state   r_state;
    t_res_sel r_res_sel;
    logic     r_out_valid;
    logic     w_slot_free;

    assign w_slot_free = !r_out_valid || i_m_tready;

    always_comb begin
        o_cmd         = '0;
        o_cmd.res_sel = r_res_sel;
        unique case (r_state)
            S_IDLE:     o_cmd.load = i_s_tvalid;
            S_MUL:      ;
            S_CMP:      o_cmd.sqrt_start = !i_status.prod_match;
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
            end
            // root is final here, divide the count by it
            S_ROOT_DIV: o_cmd.div_start = 1'b1;
            S_DIV_ROOT: begin
                o_cmd.save_root = i_status.div_done;
                o_cmd.scan_init = i_status.div_done && !i_status.rem_zero;
            end
            S_SCAN_CHK: begin
                o_cmd.div_start = !i_status.scan_over;
                o_cmd.div_scan  = 1'b1;
            end
            S_DIV_SCAN: begin
                o_cmd.scan_next = i_status.div_done && !i_status.rem_zero;
            end
            S_FINISH:   o_cmd.res_load = w_slot_free;
            default:    ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_sel   <= RES_SAME;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (i_status.prod_match) begin
                        r_res_sel <= RES_SAME;
                        r_state   <= S_FINISH;
                    end else begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (i_status.sqrt_last) begin
                        r_state <= S_ROOT_DIV;
                    end
                end
                S_ROOT_DIV: begin
                    r_state <= S_DIV_ROOT;
                end
                S_DIV_ROOT: begin
                    // divider was started in the cycle before this state
                    if (i_status.div_done) begin
                        if (i_status.rem_zero) begin
                            r_res_sel <= RES_DIV;
                            r_state   <= S_FINISH;
                        end else begin
                            r_state <= S_SCAN_CHK;
                        end
                    end
                end
                S_SCAN_CHK: begin
                    if (i_status.scan_over) begin
                        r_res_sel <= i_status.below_limit ? RES_SMALL : RES_CEIL;
                        r_state   <= S_FINISH;
                    end else begin
                        r_state <= S_DIV_SCAN;
                    end
                end
                S_DIV_SCAN: begin
                    if (i_status.div_done) begin
                        if (i_status.rem_zero) begin
                            r_res_sel <= RES_DIV;
                            r_state   <= S_FINISH;
                        end else begin
                            r_state <= S_SCAN_CHK;
                        end
                    end
                end
                S_FINISH: begin
                    if (w_slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

    `GFF_ASSERT_RST(a_ctrl_load_slot_free, i_clk, i_rst_n,
        o_cmd.res_load |-> (!r_out_valid || i_m_tready))
    `GFF_ASSERT_RST(a_ctrl_no_result_after_accept, i_clk, i_rst_n,
        (i_s_tvalid && o_s_tready) |=> !o_cmd.res_load)
    `GFF_ASSERT_RST(a_ctrl_no_div_in_sqrt, i_clk, i_rst_n,
        (r_state == S_SQRT) |-> !i_status.div_done)
    `GFF_ASSERT_ALWAYS(a_ctrl_no_valid_in_reset, i_clk,
        !i_rst_n |=> !o_m_tvalid)

endmodule
